// ===== sv/lats_pkg.sv =====
// Shared constants, command codes and controller/datapath interface types.
package lats_pkg;

    localparam int ROWS   = 32;
    localparam int COLS   = 128;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int ROW_AW = $clog2(ROWS);
    localparam int COL_AW = $clog2(COLS);
    localparam int CNT_W  = $clog2(ROWS + 3);

    typedef enum logic [1:0] {
        CMD_WRITE   = 2'd0,
        CMD_READ    = 2'd1,
        CMD_ADVANCE = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

    // Source of the row below the one being computed
    typedef enum logic [1:0] {
        NXT_RDATA = 2'd0,
        NXT_LAST  = 2'd1,
        NXT_FIRST = 2'd2
    } next_sel_t;

    typedef struct packed {
        logic              capture;
        logic              rd_en;
        logic              rd_from_input;
        logic [ROW_AW-1:0] rd_addr;
        logic              cell_wr;
        logic              load_last;
        logic              load_first;
        logic              row_wr;
        next_sel_t         next_sel;
        logic [ROW_AW-1:0] row_addr;
        logic              acc_clear;
        logic              load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic slot_free;
    } dp_stat_t;

endpackage

// ===== sv/lats_ctrl.sv =====
// Controller: command sequencing for cell access and the row-by-row generation sweep.
module lats_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [1:0]             cmd,
    input  lats_pkg::dp_stat_t     stat,
    output logic                   in_stall,
    output lats_pkg::ctrl_cmd_t    ctrl
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WBACK,
        ST_ADV,
        ST_DONE
    } state_t;

    state_t                        state_reg, state_next;
    logic [lats_pkg::CNT_W-1:0]    k_reg, k_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        ctrl       = '0;
        ctrl.next_sel = lats_pkg::NXT_RDATA;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.capture = 1'b1;
                    unique case (lats_pkg::cmd_t'(cmd))
                        lats_pkg::CMD_WRITE:
                        begin
                            // fetch the row so the single cell can be merged in
                            ctrl.rd_en         = 1'b1;
                            ctrl.rd_from_input = 1'b1;
                            state_next         = ST_WBACK;
                        end
                        lats_pkg::CMD_READ:
                        begin
                            ctrl.rd_en         = 1'b1;
                            ctrl.rd_from_input = 1'b1;
                            state_next         = ST_DONE;
                        end
                        lats_pkg::CMD_ADVANCE:
                        begin
                            // bottom row first: it is the upper neighbour of row 0
                            ctrl.rd_en     = 1'b1;
                            ctrl.rd_addr   = lats_pkg::ROW_AW'(lats_pkg::ROWS - 1);
                            ctrl.acc_clear = 1'b1;
                            k_next         = lats_pkg::CNT_W'(1);
                            state_next     = ST_ADV;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_WBACK:
            begin
                ctrl.cell_wr = 1'b1;
                state_next   = ST_DONE;
            end
            ST_ADV:
            begin
                ctrl.rd_en      = (k_reg < lats_pkg::CNT_W'(lats_pkg::ROWS));
                ctrl.rd_addr    = lats_pkg::ROW_AW'(k_reg - lats_pkg::CNT_W'(1));
                ctrl.load_last  = (k_reg == lats_pkg::CNT_W'(1));
                ctrl.load_first = (k_reg == lats_pkg::CNT_W'(2));
                ctrl.row_wr     = (k_reg >= lats_pkg::CNT_W'(3));
                ctrl.row_addr   = lats_pkg::ROW_AW'(k_reg - lats_pkg::CNT_W'(3));
                if (k_reg <= lats_pkg::CNT_W'(lats_pkg::ROWS))
                    ctrl.next_sel = lats_pkg::NXT_RDATA;
                else if (k_reg == lats_pkg::CNT_W'(lats_pkg::ROWS + 1))
                    ctrl.next_sel = lats_pkg::NXT_LAST;
                else
                    ctrl.next_sel = lats_pkg::NXT_FIRST;
                k_next = k_reg + lats_pkg::CNT_W'(1);
                if (k_reg == lats_pkg::CNT_W'(lats_pkg::ROWS + 2))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output slot can take the result
                if (stat.slot_free)
                begin
                    ctrl.load_out = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

endmodule

// ===== sv/lats_dp.sv =====
// Datapath: grid row memory, row window, next-generation row logic and output slot.
module lats_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lats_pkg::ctrl_cmd_t         ctrl,
    input  logic [1:0]                  cmd,
    input  logic [lats_pkg::ROW_W-1:0]  row,
    input  logic [lats_pkg::COL_W-1:0]  col,
    input  logic                        cell_req,
    input  logic                        out_stall,
    output lats_pkg::dp_stat_t          stat,
    output logic                        out_valid,
    output logic                        cell_out,
    output logic                        changed
);

    function automatic logic [lats_pkg::COLS-1:0] life_row(
        input logic [lats_pkg::COLS-1:0] up,
        input logic [lats_pkg::COLS-1:0] mid,
        input logic [lats_pkg::COLS-1:0] dn
    );
        logic [lats_pkg::COLS-1:0] res;
        logic [3:0]                n;
        int                        lf;
        int                        rt;
        res = '0;
        for (int c = 0; c < lats_pkg::COLS; c++)
        begin
            lf = (c + lats_pkg::COLS - 1) % lats_pkg::COLS;
            rt = (c + 1) % lats_pkg::COLS;
            n  = 4'(up[lf]) + 4'(up[c]) + 4'(up[rt]) + 4'(mid[lf]) + 4'(mid[rt])
               + 4'(dn[lf]) + 4'(dn[c]) + 4'(dn[rt]);
            res[c] = (n == 4'd3) || ((n == 4'd2) && mid[c]);
        end
        return res;
    endfunction

    logic [lats_pkg::COLS-1:0]   mem [lats_pkg::ROWS];
    logic [lats_pkg::ROWS-1:0]   row_valid_reg, row_valid_next;
    logic [lats_pkg::COLS-1:0]   mem_q_reg;
    logic                        rd_hit_reg;
    logic [lats_pkg::COLS-1:0]   rd_data;

    lats_pkg::cmd_t              cmd_reg;
    logic [lats_pkg::ROW_W-1:0]  row_reg;
    logic [lats_pkg::COL_W-1:0]  col_reg;
    logic                        cell_reg;

    logic [lats_pkg::COLS-1:0]   prev_reg, prev_next;
    logic [lats_pkg::COLS-1:0]   cur_reg, cur_next;
    logic [lats_pkg::COLS-1:0]   first_reg, first_next;
    logic [lats_pkg::COLS-1:0]   last_reg, last_next;
    logic                        acc_reg, acc_next;

    logic                        out_valid_reg, out_valid_next;
    logic                        cell_out_reg, cell_out_next;
    logic                        changed_reg, changed_next;

    logic [lats_pkg::ROW_AW-1:0] rd_addr;
    logic                        wr_en;
    logic [lats_pkg::ROW_AW-1:0] wr_addr;
    logic [lats_pkg::COLS-1:0]   wr_data;
    logic [lats_pkg::COLS-1:0]   below;
    logic [lats_pkg::COLS-1:0]   new_row;
    logic [lats_pkg::COLS-1:0]   cell_row;
    logic [lats_pkg::COL_AW-1:0] col_idx;
    logic                        in_range;
    logic                        cell_wr_eff;

    assign rd_data  = rd_hit_reg ? mem_q_reg : '0;
    assign col_idx  = lats_pkg::COL_AW'(col_reg);
    assign in_range = (32'(row_reg) < 32'(lats_pkg::ROWS))
                   && (32'(col_reg) < 32'(lats_pkg::COLS));
    assign rd_addr  = ctrl.rd_from_input ? lats_pkg::ROW_AW'(row) : ctrl.rd_addr;

    always_comb
    begin
        unique case (ctrl.next_sel)
            lats_pkg::NXT_RDATA: below = rd_data;
            lats_pkg::NXT_LAST:  below = last_reg;
            lats_pkg::NXT_FIRST: below = first_reg;
            default:             below = rd_data;
        endcase
    end

    assign new_row = life_row(prev_reg, cur_reg, below);

    always_comb
    begin
        cell_row          = rd_data;
        cell_row[col_idx] = cell_reg;
    end

    assign cell_wr_eff = ctrl.cell_wr && in_range;
    assign wr_en       = cell_wr_eff || ctrl.row_wr;
    assign wr_addr     = ctrl.row_wr ? ctrl.row_addr : lats_pkg::ROW_AW'(row_reg);
    assign wr_data     = ctrl.row_wr ? new_row : cell_row;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (ctrl.rd_en)
        begin
            mem_q_reg  <= mem[rd_addr];
            rd_hit_reg <= row_valid_reg[rd_addr];
        end
    end

    always_comb
    begin
        row_valid_next = row_valid_reg;
        if (wr_en)
            row_valid_next[wr_addr] = 1'b1;
    end

    // row window: above / current, with the wrap rows kept aside
    always_comb
    begin
        prev_next  = prev_reg;
        cur_next   = cur_reg;
        first_next = first_reg;
        last_next  = last_reg;
        if (ctrl.load_last)
        begin
            last_next = rd_data;
            prev_next = rd_data;
        end
        if (ctrl.load_first)
        begin
            first_next = rd_data;
            cur_next   = rd_data;
        end
        if (ctrl.row_wr)
        begin
            prev_next = cur_reg;
            cur_next  = below;
        end
    end

    assign acc_next = ctrl.acc_clear ? 1'b0
                    : (acc_reg || (ctrl.row_wr && (new_row != cur_reg)));

    assign stat.slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        cell_out_next  = cell_out_reg;
        changed_next   = changed_reg;
        if (ctrl.load_out)
        begin
            out_valid_next = 1'b1;
            cell_out_next  = (cmd_reg == lats_pkg::CMD_READ) && in_range && rd_data[col_idx];
            changed_next   = (cmd_reg == lats_pkg::CMD_ADVANCE) && acc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg  <= lats_pkg::cmd_t'(cmd);
            row_reg  <= row;
            col_reg  <= col;
            cell_reg <= cell_req;
        end
        prev_reg     <= prev_next;
        cur_reg      <= cur_next;
        first_reg    <= first_next;
        last_reg     <= last_next;
        acc_reg      <= acc_next;
        cell_out_reg <= cell_out_next;
        changed_reg  <= changed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_valid_reg <= row_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign cell_out  = cell_out_reg;
    assign changed   = changed_reg;

endmodule

// ===== sv/life_automaton_torus_step.sv =====
// Top level: toroidal life grid with cell write/read and whole-grid generation step.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   in      | receive   | in_valid / in_stall   | cmd, row, col, cell_req
//   out     | send      | out_valid / out_stall | cell_out, changed
//
// One item at a time. Read and unused commands go straight to the result, write
// merges its cell in first, and advance sweeps one memory row per cycle through the
// single read port, with a three-row window and the wrap rows held in registers.
// Reset clears the grid at once through per-row valid bits; no clearing pass.
// A stalled result waits in the output register; the next item may still be taken
// and worked, and its result is held back in the controller until that register frees.
module life_automaton_torus_step (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  cmd,
    input  logic [lats_pkg::ROW_W-1:0]  row,
    input  logic [lats_pkg::COL_W-1:0]  col,
    input  logic                        cell_req,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        cell_out,
    output logic                        changed
);

    lats_pkg::ctrl_cmd_t ctrl;
    lats_pkg::dp_stat_t  stat;

    lats_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .cmd      (cmd),
        .stat     (stat),
        .in_stall (in_stall),
        .ctrl     (ctrl)
    );

    lats_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .cmd       (cmd),
        .row       (row),
        .col       (col),
        .cell_req  (cell_req),
        .out_stall (out_stall),
        .stat      (stat),
        .out_valid (out_valid),
        .cell_out  (cell_out),
        .changed   (changed)
    );

    // an accepted item always holds the input stalled right after it is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken again straight after an accept");

    // a read result and a change flag never come together
    a_exclusive_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(cell_out && changed))
        else $error("cell_out and changed both set");

    // loading a result returns the controller to idle
    a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_stall)
        else $error("result loaded while controller still busy");

endmodule

// ===== sim/life_grid_check.sv =====
// Checker for the toroidal life grid: predicts each result and compares it with the block.
module life_grid_check (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic [1:0]                 cmd,
    input  logic [lats_pkg::ROW_W-1:0] row,
    input  logic [lats_pkg::COL_W-1:0] col,
    input  logic                       cell_req,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic                       cell_out,
    input  logic                       changed,
    output int                         fail_count,
    output int                         result_count,
    output int                         owed_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS = lats_pkg::ROWS;
    localparam int COLS = lats_pkg::COLS;

    typedef struct packed {
        logic cell_out;
        logic changed;
    } step_result_t;

    logic [COLS-1:0] life_grid [ROWS];
    step_result_t    owed_results [$];

    // Compute one generation in place; return whether any cell flipped.
    function automatic logic next_generation();
        logic [COLS-1:0] fresh [ROWS];
        logic            any_flip;
        int              n;
        any_flip = 1'b0;
        for (int r = 0; r < ROWS; r++)
        begin
            for (int c = 0; c < COLS; c++)
            begin
                n = 0;
                for (int dr = -1; dr <= 1; dr++)
                begin
                    for (int dc = -1; dc <= 1; dc++)
                    begin
                        if (dr != 0 || dc != 0)
                            n += life_grid[(r + ROWS + dr) % ROWS][(c + COLS + dc) % COLS];
                    end
                end
                fresh[r][c] = (n == 3) || (n == 2 && life_grid[r][c]);
                if (fresh[r][c] != life_grid[r][c])
                    any_flip = 1'b1;
            end
        end
        for (int r = 0; r < ROWS; r++)
            life_grid[r] = fresh[r];
        return any_flip;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        step_result_t got;
        step_result_t want;
        int           errs;
        errs = 0;
        if (!rst_n)
        begin
            for (int r = 0; r < ROWS; r++)
                life_grid[r] = '0;
            owed_results.delete();
            fail_count   <= 0;
            result_count <= 0;
            owed_count   <= 0;
        end
        else
        begin
            // Retire the leaving result before taking the new item.
            if (out_valid && !out_stall)
            begin
                got.cell_out = cell_out;
                got.changed  = changed;
                result_count <= result_count + 1;
                if (owed_results.size() == 0)
                begin
                    $display("%0t: result with no item waiting: cell_out %0b changed %0b",
                             $time, got.cell_out, got.changed);
                    errs++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (got.cell_out !== want.cell_out)
                    begin
                        $display("%0t: cell_out expected %0b actual %0b",
                                 $time, want.cell_out, got.cell_out);
                        errs++;
                    end
                    if (got.changed !== want.changed)
                    begin
                        $display("%0t: changed expected %0b actual %0b",
                                 $time, want.changed, got.changed);
                        errs++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                want = '0;
                case (lats_pkg::cmd_t'(cmd))
                    lats_pkg::CMD_WRITE:   life_grid[row][col] = cell_req;
                    lats_pkg::CMD_READ:    want.cell_out = life_grid[row][col];
                    lats_pkg::CMD_ADVANCE: want.changed = next_generation();
                    default:               ;
                endcase
                owed_results.push_back(want);
            end
            fail_count <= fail_count + errs;
            owed_count <= owed_results.size();
        end
    end

endmodule

// ===== sim/tb.sv =====
// Testbench top: drives commands into the life grid block and gives the verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS         = lats_pkg::ROWS;
    localparam int COLS         = lats_pkg::COLS;
    localparam int ROW_W        = lats_pkg::ROW_W;
    localparam int COL_W        = lats_pkg::COL_W;
    localparam int RANDOM_ITEMS = 1500;
    localparam int LONG_HOLD_AT = 400;
    localparam int LONG_HOLD    = 300;
    localparam int CYCLE_LIMIT  = 400000;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic [1:0]       cmd;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             cell_req;
    logic             out_valid;
    logic             out_stall;
    logic             cell_out;
    logic             changed;

    int fail_count;
    int result_count;
    int owed_count;
    int items_sent;
    int cycle_count;
    logic steady;

    life_automaton_torus_step u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .row       (row),
        .col       (col),
        .cell_req  (cell_req),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cell_out  (cell_out),
        .changed   (changed)
    );

    life_grid_check u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .row          (row),
        .col          (col),
        .cell_req     (cell_req),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .cell_out     (cell_out),
        .changed      (changed),
        .fail_count   (fail_count),
        .result_count (result_count),
        .owed_count   (owed_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Offer one item after a random gap, or none in steady runs, and hold it until taken.
    task automatic push_item(input lats_pkg::cmd_t op, input int r, input int k,
                             input logic v);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= op;
        row      <= r[ROW_W-1:0];
        col      <= k[COL_W-1:0];
        cell_req <= v;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    // Receiver: random hold-off per result, calm runs, and one long stretch.
    initial
    begin : receiver
        int hold;
        int calm;
        int taken;
        hold  = 0;
        calm  = 0;
        taken = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                taken++;
                if (calm > 0)
                    calm--;
                else if ($urandom_range(0, 9) == 0)
                    calm = $urandom_range(5, 40);
                if (taken == LONG_HOLD_AT)
                    hold = LONG_HOLD;
                else
                    hold = (calm > 0) ? 0 : $urandom_range(0, 3);
            end
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                hold--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin : stimulus
        int kind;
        int base_r;
        int base_c;
        int target;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        cmd        <= lats_pkg::CMD_NOP;
        row        <= '0;
        col        <= '0;
        cell_req   <= 1'b0;
        items_sent = 0;
        steady     = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty grid: advance reports no change, ignoring all-ones fields.
        push_item(lats_pkg::CMD_ADVANCE, ROWS - 1, COLS - 1, 1'b1);
        push_item(lats_pkg::CMD_READ, 0, 0, 1'b1);
        push_item(lats_pkg::CMD_READ, ROWS - 1, COLS - 1, 1'b0);
        push_item(lats_pkg::CMD_WRITE, 0, 0, 1'b1);
        push_item(lats_pkg::CMD_WRITE, ROWS - 1, COLS - 1, 1'b1);
        push_item(lats_pkg::CMD_READ, 0, 0, 1'b0);
        push_item(lats_pkg::CMD_READ, ROWS - 1, COLS - 1, 1'b0);
        push_item(lats_pkg::CMD_WRITE, 0, 0, 1'b0);
        push_item(lats_pkg::CMD_WRITE, ROWS - 1, COLS - 1, 1'b0);
        // Unused command must leave the grid alone.
        push_item(lats_pkg::CMD_NOP, ROWS - 1, COLS - 1, 1'b1);
        // Blinker straddling the column wrap, turning through the row wrap.
        push_item(lats_pkg::CMD_WRITE, 0, COLS - 1, 1'b1);
        push_item(lats_pkg::CMD_WRITE, 0, 0, 1'b1);
        push_item(lats_pkg::CMD_WRITE, 0, 1, 1'b1);
        push_item(lats_pkg::CMD_ADVANCE, 0, 0, 1'b0);
        push_item(lats_pkg::CMD_READ, ROWS - 1, 0, 1'b0);
        push_item(lats_pkg::CMD_READ, 1, 0, 1'b0);
        push_item(lats_pkg::CMD_READ, 0, COLS - 1, 1'b1);
        push_item(lats_pkg::CMD_ADVANCE, 17, 85, 1'b1);
        push_item(lats_pkg::CMD_WRITE, 0, COLS - 1, 1'b0);
        push_item(lats_pkg::CMD_WRITE, 0, 0, 1'b0);
        push_item(lats_pkg::CMD_WRITE, 0, 1, 1'b0);
        // Still life: advance alters nothing.
        push_item(lats_pkg::CMD_WRITE, 15, 63, 1'b1);
        push_item(lats_pkg::CMD_WRITE, 15, 64, 1'b1);
        push_item(lats_pkg::CMD_WRITE, 16, 63, 1'b1);
        push_item(lats_pkg::CMD_WRITE, 16, 64, 1'b1);
        push_item(lats_pkg::CMD_ADVANCE, 0, 0, 1'b0);

        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            kind   = $urandom_range(0, 99);
            steady = ($urandom_range(0, 7) == 0);
            base_r = $urandom_range(0, ROWS - 1);
            base_c = $urandom_range(0, COLS - 1);
            if (kind < 60)
            begin
                // Seed a small cluster, evolve it, then probe around it.
                repeat ($urandom_range(3, 8))
                    push_item(lats_pkg::CMD_WRITE, (base_r + $urandom_range(0, 3)) % ROWS,
                              (base_c + $urandom_range(0, 3)) % COLS,
                              $urandom_range(0, 9) < 7);
                repeat ($urandom_range(1, 3))
                    push_item(lats_pkg::CMD_ADVANCE, $urandom_range(0, ROWS - 1),
                              $urandom_range(0, COLS - 1), $urandom_range(0, 1));
                repeat ($urandom_range(2, 5))
                    push_item(lats_pkg::CMD_READ,
                              (base_r + ROWS - 1 + $urandom_range(0, 5)) % ROWS,
                              (base_c + COLS - 1 + $urandom_range(0, 5)) % COLS,
                              $urandom_range(0, 1));
            end
            else if (kind < 80)
            begin
                repeat ($urandom_range(1, 4))
                    push_item(lats_pkg::cmd_t'($urandom_range(0, 3)),
                              $urandom_range(0, ROWS - 1),
                              $urandom_range(0, COLS - 1), $urandom_range(0, 1));
            end
            else if (kind < 90)
            begin
                repeat ($urandom_range(1, 6))
                    push_item(lats_pkg::CMD_READ, $urandom_range(0, ROWS - 1),
                              $urandom_range(0, COLS - 1), $urandom_range(0, 1));
            end
            else
            begin
                // Clear a patch so that quiet generations turn up too.
                for (int dr = 0; dr < 4; dr++)
                begin
                    for (int dc = 0; dc < 4; dc++)
                        push_item(lats_pkg::CMD_WRITE, (base_r + dr) % ROWS,
                                  (base_c + dc) % COLS, 1'b0);
                end
                push_item(lats_pkg::CMD_ADVANCE, base_r, base_c, 1'b1);
            end
        end
        in_valid <= 1'b0;

        wait (result_count >= items_sent);
        repeat (ROWS + 8) @(posedge clk);
        if (fail_count == 0 && owed_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== life_automaton_torus_step.f =====
sv/lats_pkg.sv
sv/lats_ctrl.sv
sv/lats_dp.sv
sv/life_automaton_torus_step.sv
sim/life_grid_check.sv
sim/tb.sv
